// File: design/snv_pkg.sv
// Shared types and constants for the subject name validator.
// Used by the configuration register block and the top level.
// No dependencies.
package snv_pkg;

	// Name limits.
	localparam int unsigned MAX_NAME_LEN = 255;
	localparam int unsigned MAX_ELEM_LEN = 127;
	localparam int unsigned MAX_ELEMENTS = 32;

	// Counter widths; each counter holds one above its limit.
	localparam int unsigned NAME_LEN_W = $clog2(MAX_NAME_LEN + 2);
	localparam int unsigned ELEM_LEN_W = $clog2(MAX_ELEM_LEN + 2);
	localparam int unsigned ELEM_CNT_W = 6;

	// Configuration port geometry.
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Register indexes (byte address is four times the index).
	typedef enum logic [1:0] {
		REG_SEPARATOR = 2'd0,
		REG_ANY_WC    = 2'd1,
		REG_TAIL_WC   = 2'd2
	} reg_idx_t;

	// Verdict codes.
	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_EMPTY_NAME   = 3'd1,
		ERR_TOO_LONG     = 3'd2,
		ERR_TOO_MANY     = 3'd3,
		ERR_EMPTY_ELEM   = 3'd4,
		ERR_ELEM_LONG    = 3'd5,
		ERR_TAIL_NOTLAST = 3'd6,
		ERR_EMBEDDED_WC  = 3'd7
	} err_code_t;

	// Character configuration seen by the datapath.
	typedef struct packed {
		logic [7:0] separator;
		logic [7:0] any_wc;
		logic [7:0] tail_wc;
	} cfg_t;

	// Reset values of the character registers.
	localparam logic [7:0] SEPARATOR_RST = 8'd46;
	localparam logic [7:0] ANY_WC_RST    = 8'd42;
	localparam logic [7:0] TAIL_WC_RST   = 8'd62;

endpackage

// File: design/subject_name_validator.sv
// Subject name validator: one name byte per cycle, verdict on the zero byte.
// The verdict is registered in the result register as its zero byte leaves the input register.
// Single input and result registers; a zero byte waits while a held result is stalled.
// Reset: arst_n resets valid flags, name state and the character registers.
// Depends on snv_pkg and snv_cfg.
module subject_name_validator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [snv_pkg::ADDR_W-1:0] paddr,
	input  logic [snv_pkg::DATA_W-1:0] pwdata,
	output logic [snv_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       name_valid,
	output logic                       name_stall,
	input  logic [7:0]                 name_byte,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       name_ok,
	output logic [2:0]                 error_code,
	output logic [5:0]                 error_element,
	output logic                       is_pattern,
	output logic [5:0]                 element_total,
	output logic [8:0]                 name_length
);
	import snv_pkg::*;

	cfg_t cfg;

	snv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register.
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       is_end;

	// Name state.
	logic [NAME_LEN_W-1:0] name_len_q;
	logic [ELEM_LEN_W-1:0] elem_len_q;
	logic [ELEM_CNT_W-1:0] elem_cnt_q;
	logic                  has_any_q;
	logic                  has_tail_q;
	err_code_t             perr_code_q;
	logic [ELEM_CNT_W-1:0] perr_elem_q;
	err_code_t             merr_code_q;
	logic [ELEM_CNT_W-1:0] merr_elem_q;
	logic                  pattern_q;

	// Result register.
	logic                  out_vld_q;
	logic                  ok_q;
	err_code_t             code_q;
	logic [ELEM_CNT_W-1:0] elem_q;
	logic                  pat_q;
	logic [ELEM_CNT_W-1:0] total_q;
	logic [NAME_LEN_W-1:0] len_q;

	// A non-zero byte never produces a result, so it always moves on.
	assign is_end     = (byte_s1 == 8'd0);
	assign adv        = vld_s1 & (!is_end | !out_vld_q | !result_stall);
	assign name_stall = vld_s1 & !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || adv) begin
			vld_s1 <= name_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!vld_s1 || adv) && name_valid) begin
			byte_s1 <= name_byte;
		end
	end

	// Element close, shared by a separator and the end byte.
	logic      last_close;
	err_code_t close_perr;
	err_code_t close_merr;
	logic      close_pat;
	logic      len_one;

	assign last_close = is_end;
	assign len_one    = (elem_len_q == ELEM_LEN_W'(1));

	always_comb begin
		close_perr = ERR_NONE;
		close_merr = merr_code_q;
		close_pat  = pattern_q;
		if (elem_len_q == '0) begin
			close_perr = ERR_EMPTY_ELEM;
		end else if (elem_len_q > ELEM_LEN_W'(MAX_ELEM_LEN)) begin
			close_perr = ERR_ELEM_LONG;
		end else if (merr_code_q == ERR_NONE) begin
			if (len_one && has_any_q) begin
				close_pat = 1'b1;
			end else if (len_one && has_tail_q) begin
				if (last_close) begin
					close_pat = 1'b1;
				end else begin
					close_merr = ERR_TAIL_NOTLAST;
				end
			end else if (has_any_q || has_tail_q) begin
				close_merr = ERR_EMBEDDED_WC;
			end
		end
	end

	// Byte classification for the streaming update.
	logic is_sep;
	logic at_limit;
	logic name_sat;
	logic elem_sat;

	assign is_sep   = (byte_s1 == cfg.separator);
	assign at_limit = (elem_cnt_q == ELEM_CNT_W'(MAX_ELEMENTS));
	assign name_sat = (name_len_q > NAME_LEN_W'(MAX_NAME_LEN));
	assign elem_sat = (elem_len_q > ELEM_LEN_W'(MAX_ELEM_LEN));

	// Streaming state update; the end byte resets all name state for the next name.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q  <= '0;
			elem_len_q  <= '0;
			elem_cnt_q  <= ELEM_CNT_W'(1);
			has_any_q   <= 1'b0;
			has_tail_q  <= 1'b0;
			perr_code_q <= ERR_NONE;
			perr_elem_q <= '0;
			merr_code_q <= ERR_NONE;
			merr_elem_q <= '0;
			pattern_q   <= 1'b0;
		end else if (adv) begin
			if (is_end) begin
				name_len_q  <= '0;
				elem_len_q  <= '0;
				elem_cnt_q  <= ELEM_CNT_W'(1);
				has_any_q   <= 1'b0;
				has_tail_q  <= 1'b0;
				perr_code_q <= ERR_NONE;
				perr_elem_q <= '0;
				merr_code_q <= ERR_NONE;
				merr_elem_q <= '0;
				pattern_q   <= 1'b0;
			end else begin
				if (!name_sat) begin
					name_len_q <= name_len_q + NAME_LEN_W'(1);
				end
				if (perr_code_q == ERR_NONE) begin
					if (at_limit) begin
						perr_code_q <= ERR_TOO_MANY;
						perr_elem_q <= '0;
					end else if (is_sep) begin
						if (close_perr != ERR_NONE) begin
							perr_code_q <= close_perr;
							perr_elem_q <= elem_cnt_q;
						end else begin
							if (merr_code_q == ERR_NONE && close_merr != ERR_NONE) begin
								merr_code_q <= close_merr;
								merr_elem_q <= elem_cnt_q;
							end
							pattern_q  <= close_pat;
							elem_cnt_q <= elem_cnt_q + ELEM_CNT_W'(1);
							elem_len_q <= '0;
							has_any_q  <= 1'b0;
							has_tail_q <= 1'b0;
						end
					end else begin
						if (!elem_sat) begin
							elem_len_q <= elem_len_q + ELEM_LEN_W'(1);
						end
						if (byte_s1 == cfg.any_wc) begin
							has_any_q <= 1'b1;
						end
						if (byte_s1 == cfg.tail_wc) begin
							has_tail_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// Verdict for the end byte, ranked as empty, too long, parse, wildcard.
	err_code_t             v_code;
	logic [ELEM_CNT_W-1:0] v_elem;
	logic                  v_pat;
	logic [ELEM_CNT_W-1:0] v_total;

	always_comb begin
		v_code  = ERR_NONE;
		v_elem  = '0;
		v_pat   = 1'b0;
		v_total = '0;
		if (name_len_q == '0) begin
			v_code = ERR_EMPTY_NAME;
		end else if (name_sat) begin
			v_code = ERR_TOO_LONG;
		end else if (perr_code_q != ERR_NONE) begin
			v_code  = perr_code_q;
			v_elem  = perr_elem_q;
			v_total = elem_cnt_q;
		end else if (close_perr != ERR_NONE) begin
			v_code  = close_perr;
			v_elem  = elem_cnt_q;
			v_total = elem_cnt_q;
		end else if (merr_code_q != ERR_NONE) begin
			v_code  = merr_code_q;
			v_elem  = merr_elem_q;
			v_pat   = pattern_q;
			v_total = elem_cnt_q;
		end else if (close_merr != ERR_NONE) begin
			v_code  = close_merr;
			v_elem  = elem_cnt_q;
			v_pat   = pattern_q;
			v_total = elem_cnt_q;
		end else begin
			v_pat   = close_pat;
			v_total = elem_cnt_q;
		end
	end

	// Result register valid; it frees when the downstream takes the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && is_end) begin
			out_vld_q <= 1'b1;
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_end) begin
			ok_q    <= (v_code == ERR_NONE);
			code_q  <= v_code;
			elem_q  <= v_elem;
			pat_q   <= v_pat;
			total_q <= v_total;
			len_q   <= name_len_q;
		end
	end

	assign result_valid  = out_vld_q;
	assign name_ok       = ok_q;
	assign error_code    = code_q;
	assign error_element = elem_q;
	assign is_pattern    = pat_q;
	assign element_total = total_q;
	assign name_length   = len_q;

`ifndef ASSERT_OFF
	// The pass flag agrees with the error code.
	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (ok_q == (code_q == ERR_NONE)))
		else $error("name_ok disagrees with error_code");

	// An empty-name verdict carries no length and no elements.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && code_q == ERR_EMPTY_NAME) |-> (len_q == '0 && total_q == '0))
		else $error("empty name verdict with non-zero counts");

	// Too many elements reports the element limit as the total.
	a_too_many_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && code_q == ERR_TOO_MANY) |->
		(total_q == ELEM_CNT_W'(MAX_ELEMENTS) && elem_q == '0))
		else $error("too many elements verdict with wrong counts");

	// An end byte that moves on always leaves a pending result.
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_end) |=> out_vld_q)
		else $error("end byte accepted without a result");

	// The element counter never runs past its limit.
	a_elem_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(elem_cnt_q <= ELEM_CNT_W'(MAX_ELEMENTS)) && (elem_cnt_q != '0))
		else $error("element counter out of range");
`endif

endmodule

// File: design/snv_cfg.sv
// Configuration registers of the subject name validator behind an APB-style port.
// Depends on snv_pkg for the register map and the cfg_t struct.
module snv_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [snv_pkg::ADDR_W-1:0] paddr,
	input  logic [snv_pkg::DATA_W-1:0] pwdata,
	output logic [snv_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output snv_pkg::cfg_t              cfg
);
	import snv_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t widx;
	logic     wr_en;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.separator <= SEPARATOR_RST;
			cfg_q.any_wc    <= ANY_WC_RST;
			cfg_q.tail_wc   <= TAIL_WC_RST;
		end else if (wr_en) begin
			case (widx)
				REG_SEPARATOR: cfg_q.separator <= pwdata[7:0];
				REG_ANY_WC:    cfg_q.any_wc    <= pwdata[7:0];
				REG_TAIL_WC:   cfg_q.tail_wc   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read mux; unmapped addresses read as zero.
	always_comb begin
		prdata = '0;
		case (widx)
			REG_SEPARATOR: prdata[7:0] = cfg_q.separator;
			REG_ANY_WC:    prdata[7:0] = cfg_q.any_wc;
			REG_TAIL_WC:   prdata[7:0] = cfg_q.tail_wc;
			default:       prdata      = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
